// File: design/bsi_pkg.sv
package bsi_pkg;

    localparam int FIELD_W = 48;
    localparam int CMD_W   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_BOX_BOX       = 3'd0,
        CMD_POINT_BOX     = 3'd1,
        CMD_SPHERE_BOX    = 3'd2,
        CMD_SPHERE_SPHERE = 3'd3,
        CMD_POINT_SPHERE  = 3'd4
    } t_cmd;

    // Per-stage load enables, shared by the lanes and the merge stage
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_pipe_ctl;

endpackage

// File: design/bsi_query_if.sv
interface bsi_query_if import bsi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [FIELD_W-1:0] a_center;
    logic [FIELD_W-1:0] a_extent;
    logic [FIELD_W-1:0] b_center;
    logic [FIELD_W-1:0] b_extent;

    modport source (
        output valid, command, a_center, a_extent, b_center, b_extent,
        input  ready
    );
    modport sink (
        input  valid, command, a_center, a_extent, b_center, b_extent,
        output ready
    );
endinterface

// File: design/bsi_result_if.sv
interface bsi_result_if ();
    logic valid;
    logic ready;
    logic hit;
    logic bad_command;

    modport source (
        output valid, hit, bad_command,
        input  ready
    );
    modport sink (
        input  valid, hit, bad_command,
        output ready
    );
endinterface

// File: design/box_sphere_intersection_unit.sv
// Channel    Dir   Transfer when        Payload
// i_query    in    valid && ready       command, a_center, a_extent, b_center, b_extent
// o_result   out   valid && ready       hit, bad_command
//
// One query per cycle while the result channel is not stalled; each query passes
// three register stages before its result is offered.
// Three axis lanes bound, test, clamp and square in two stages; the merge stage sums
// the squares, compares with the squared radius or ANDs the box tests, and holds the result register.
// A stalled result holds its stage; earlier stages keep filling behind it.
// Synchronous active-low reset empties the pipeline.
module box_sphere_intersection_unit import bsi_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bsi_query_if.sink    i_query,
    bsi_result_if.source o_result
);

    localparam int WORD_W = (3 * COORD_BITS > FIELD_W) ? 3 * COORD_BITS : FIELD_W;
    localparam int SQ_W   = 2 * (COORD_BITS + 3);

    logic [WORD_W-1:0]            a_ctr_w, a_ext_w, b_ctr_w, b_ext_w;
    t_pipe_ctl                    ctl;
    logic                         accept;
    logic                         r_v1, r_v2, r_v3;
    logic [2:0]                   box_ok;
    logic [2:0][SQ_W-1:0]         sq;

    // Zero-extend so that a wide z lane reads zeros above the field
    assign a_ctr_w = WORD_W'(i_query.a_center);
    assign a_ext_w = WORD_W'(i_query.a_extent);
    assign b_ctr_w = WORD_W'(i_query.b_center);
    assign b_ext_w = WORD_W'(i_query.b_extent);

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        ctl.en3 = !r_v3 || o_result.ready;
        ctl.en2 = !r_v2 || ctl.en3;
        ctl.en1 = !r_v1 || ctl.en2;
    end

    assign i_query.ready = ctl.en1;
    assign accept        = i_query.valid && ctl.en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ctl.en1) begin
                r_v1 <= accept;
            end
            if (ctl.en2) begin
                r_v2 <= r_v1;
            end
            if (ctl.en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    for (genvar ax = 0; ax < 3; ax++) begin : g_lane
        bsi_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_cmd    (i_query.command),
            .i_a_ctr  (a_ctr_w[ax*COORD_BITS +: COORD_BITS]),
            .i_a_ext  (a_ext_w[ax*COORD_BITS +: COORD_BITS]),
            .i_b_ctr  (b_ctr_w[ax*COORD_BITS +: COORD_BITS]),
            .i_b_ext  (b_ext_w[ax*COORD_BITS +: COORD_BITS]),
            .o_box_ok (box_ok[ax]),
            .o_sq     (sq[ax])
        );
    end

    bsi_merge #(
        .COORD_BITS (COORD_BITS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_cmd    (i_query.command),
        .i_a_rad  (a_ext_w[COORD_BITS-1:0]),
        .i_b_rad  (b_ext_w[COORD_BITS-1:0]),
        .i_box_ok (box_ok),
        .i_sq     (sq),
        .o_hit    (o_result.hit),
        .o_bad    (o_result.bad_command)
    );

    assign o_result.valid = r_v3;

`ifndef NO_ASSERTIONS
    a_hit_bad_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !(o_result.hit && o_result.bad_command))
        else $error("hit and bad_command both set");

    a_free_slot_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v3 |-> i_query.ready)
        else $error("input stalled while result stage is empty");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && !o_result.ready) |-> !i_query.ready)
        else $error("transfer taken into a full pipeline");
`endif

endmodule

// File: design/bsi_lane.sv
module bsi_lane import bsi_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                       i_clk,
    input  t_pipe_ctl                  i_ctl,
    input  logic [CMD_W-1:0]           i_cmd,
    input  logic [COORD_BITS-1:0]      i_a_ctr,
    input  logic [COORD_BITS-1:0]      i_a_ext,
    input  logic [COORD_BITS-1:0]      i_b_ctr,
    input  logic [COORD_BITS-1:0]      i_b_ext,
    output logic                       o_box_ok,
    output logic [2*(COORD_BITS+3)-1:0] o_sq
);

    localparam int W = COORD_BITS + 3;

    logic signed [W-1:0]   a_s, b_s, a2, b2, a_sz, b_sz;
    logic signed [W-1:0]   alo, ahi, blo, bhi, q0, q, d_clamp, d_diff;
    logic                  overlap, pt_in_box;
    logic                  n_ok;
    logic signed [W-1:0]   n_d;
    logic                  r_ok1, r_ok2;
    logic signed [W-1:0]   r_d;
    logic signed [2*W-1:0] prod;
    logic [2*W-1:0]        r_sq;

    always_comb begin
        a_s  = W'($signed(i_a_ctr));
        b_s  = W'($signed(i_b_ctr));
        a2   = a_s <<< 1;
        b2   = b_s <<< 1;
        a_sz = $signed({3'b000, i_a_ext});
        b_sz = $signed({3'b000, i_b_ext});
        alo  = a2 - a_sz;
        ahi  = a2 + a_sz;
        blo  = b2 - b_sz;
        bhi  = b2 + b_sz;

        overlap   = (alo <= bhi) && (ahi >= blo);
        // faces count as inside
        pt_in_box = (a2 >= blo) && (a2 <= bhi);

        // clamp the doubled sphere centre onto box B
        q0      = (a2 < bhi) ? a2 : bhi;
        q       = (q0 > blo) ? q0 : blo;
        d_clamp = q - a2;
        d_diff  = a_s - b_s;

        n_ok = (i_cmd == CMD_BOX_BOX) ? overlap : pt_in_box;
        n_d  = (i_cmd == CMD_SPHERE_BOX) ? d_clamp : d_diff;
    end

    assign prod = r_d * r_d;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_ok1 <= n_ok;
            r_d   <= n_d;
        end
        if (i_ctl.en2) begin
            r_ok2 <= r_ok1;
            r_sq  <= $unsigned(prod);
        end
    end

    assign o_box_ok = r_ok2;
    assign o_sq     = r_sq;

endmodule

// File: design/bsi_merge.sv
module bsi_merge import bsi_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                              i_clk,
    input  t_pipe_ctl                         i_ctl,
    input  logic [CMD_W-1:0]                  i_cmd,
    input  logic [COORD_BITS-1:0]             i_a_rad,
    input  logic [COORD_BITS-1:0]             i_b_rad,
    input  logic [2:0]                        i_box_ok,
    input  logic [2:0][2*(COORD_BITS+3)-1:0]  i_sq,
    output logic                              o_hit,
    output logic                              o_bad
);

    localparam int SQ_W  = 2 * (COORD_BITS + 3);
    localparam int SUM_W = SQ_W + 2;
    localparam int RAD_W = COORD_BITS + 1;
    localparam int R2_W  = 2 * RAD_W;

    logic [RAD_W-1:0] n_rad;
    logic [RAD_W-1:0] r_rad;
    logic [CMD_W-1:0] r_cmd1, r_cmd2;
    logic [R2_W-1:0]  r_r2;
    logic [SUM_W-1:0] sum;
    logic             near;
    logic             n_hit, n_bad;
    logic             r_hit, r_bad;

    always_comb begin
        case (i_cmd)
            CMD_SPHERE_BOX:    n_rad = {i_a_rad, 1'b0};
            CMD_SPHERE_SPHERE: n_rad = RAD_W'(i_a_rad) + RAD_W'(i_b_rad);
            CMD_POINT_SPHERE:  n_rad = RAD_W'(i_b_rad);
            default:           n_rad = '0;
        endcase
    end

    always_comb begin
        sum  = SUM_W'(i_sq[0]) + SUM_W'(i_sq[1]) + SUM_W'(i_sq[2]);
        // strict: the surface is outside
        near = sum < SUM_W'(r_r2);
        n_bad = 1'b0;
        case (r_cmd2)
            CMD_BOX_BOX,
            CMD_POINT_BOX:     n_hit = &i_box_ok;
            CMD_SPHERE_BOX,
            CMD_SPHERE_SPHERE,
            CMD_POINT_SPHERE:  n_hit = near;
            default: begin
                n_hit = 1'b0;
                n_bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_cmd1 <= i_cmd;
            r_rad  <= n_rad;
        end
        if (i_ctl.en2) begin
            r_cmd2 <= r_cmd1;
            r_r2   <= r_rad * r_rad;
        end
        if (i_ctl.en3) begin
            r_hit <= n_hit;
            r_bad <= n_bad;
        end
    end

    assign o_hit = r_hit;
    assign o_bad = r_bad;

endmodule

// File: test/tb_box_sphere_intersection_unit.sv
`timescale 1ns / 100ps

module tb_box_sphere_intersection_unit;
    import bsi_pkg::*;

    localparam int LANE_W         = 16;
    localparam int NUM_VALID_CMDS = 5;
    localparam int RANDOM_QUERIES = 1830;
    localparam int HOLD_CYCLES    = 120;

    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam logic [CMD_W-1:0] ALL_CMDS [8] = '{
        CMD_BOX_BOX, CMD_POINT_BOX, CMD_SPHERE_BOX, CMD_SPHERE_SPHERE,
        CMD_POINT_SPHERE, CMD_RSVD_5, CMD_RSVD_6, CMD_RSVD_7
    };

    localparam logic [FIELD_W-1:0] ALL_ONES = '1;

    typedef struct {
        logic [CMD_W-1:0]   command;
        logic [FIELD_W-1:0] a_center;
        logic [FIELD_W-1:0] a_extent;
        logic [FIELD_W-1:0] b_center;
        logic [FIELD_W-1:0] b_extent;
    } t_query_item;

    typedef struct {
        logic hit;
        logic bad_command;
    } t_verdict;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bsi_query_if  query_ch ();
    bsi_result_if result_ch ();

    box_sphere_intersection_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_query  (query_ch),
        .o_result (result_ch)
    );

    t_query_item pending_queries [$];
    t_verdict    expected_verdicts [$];
    t_query_item offered;

    int total_items    = 0;
    int accepted_count = 0;
    int hold_at        = 2147483647;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int failures       = 0;
    int checked_count  = 0;
    int hits_seen      = 0;
    int rejects_seen   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb_box_sphere_intersection_unit NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic longint lane_s(logic [FIELD_W-1:0] w, int idx);
        return longint'($signed(w[idx*LANE_W +: LANE_W]));
    endfunction

    function automatic longint lane_u(logic [FIELD_W-1:0] w, int idx);
        return longint'(w[idx*LANE_W +: LANE_W]);
    endfunction

    // Doubled bounds on one axis
    function automatic void box_span(logic [FIELD_W-1:0] ctr, logic [FIELD_W-1:0] ext,
                                     int ax, output longint lo, output longint hi);
        lo = 2 * lane_s(ctr, ax) - lane_u(ext, ax);
        hi = 2 * lane_s(ctr, ax) + lane_u(ext, ax);
    endfunction

    function automatic longint centre_dist_sq(logic [FIELD_W-1:0] p, logic [FIELD_W-1:0] q);
        longint d;
        longint sum;
        sum = 0;
        for (int ax = 0; ax < 3; ax++) begin
            d = lane_s(p, ax) - lane_s(q, ax);
            sum += d * d;
        end
        return sum;
    endfunction

    function automatic t_verdict predict_verdict(t_query_item q);
        t_verdict v;
        longint   alo, ahi, blo, bhi, p2, clamped, d, sum, rad;
        bit       all_in;
        v.hit         = 1'b0;
        v.bad_command = 1'b0;
        all_in        = 1'b1;
        sum           = 0;
        case (q.command)
            CMD_BOX_BOX: begin
                for (int ax = 0; ax < 3; ax++) begin
                    box_span(q.a_center, q.a_extent, ax, alo, ahi);
                    box_span(q.b_center, q.b_extent, ax, blo, bhi);
                    if (!(alo <= bhi && ahi >= blo)) all_in = 1'b0;
                end
                v.hit = all_in;
            end
            CMD_POINT_BOX: begin
                for (int ax = 0; ax < 3; ax++) begin
                    box_span(q.b_center, q.b_extent, ax, blo, bhi);
                    p2 = 2 * lane_s(q.a_center, ax);
                    if (!(p2 >= blo && p2 <= bhi)) all_in = 1'b0;
                end
                v.hit = all_in;
            end
            CMD_SPHERE_BOX: begin
                // clamp the doubled centre into the box, sum squared offsets
                for (int ax = 0; ax < 3; ax++) begin
                    box_span(q.b_center, q.b_extent, ax, blo, bhi);
                    p2      = 2 * lane_s(q.a_center, ax);
                    clamped = (p2 < bhi) ? p2 : bhi;
                    clamped = (clamped > blo) ? clamped : blo;
                    d       = clamped - p2;
                    sum += d * d;
                end
                rad   = 2 * lane_u(q.a_extent, 0);
                v.hit = (sum < rad * rad);
            end
            CMD_SPHERE_SPHERE: begin
                rad   = lane_u(q.a_extent, 0) + lane_u(q.b_extent, 0);
                v.hit = (centre_dist_sq(q.a_center, q.b_center) < rad * rad);
            end
            CMD_POINT_SPHERE: begin
                rad   = lane_u(q.b_extent, 0);
                v.hit = (centre_dist_sq(q.a_center, q.b_center) < rad * rad);
            end
            default: v.bad_command = 1'b1;
        endcase
        return v;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [FIELD_W-1:0] xyz(int x, int y, int z);
        return {LANE_W'(z), LANE_W'(y), LANE_W'(x)};
    endfunction

    function automatic t_query_item mk_query(logic [CMD_W-1:0] cmd,
                                             logic [FIELD_W-1:0] ac, logic [FIELD_W-1:0] ae,
                                             logic [FIELD_W-1:0] bc, logic [FIELD_W-1:0] be);
        t_query_item q;
        q.command  = cmd;
        q.a_center = ac;
        q.a_extent = ae;
        q.b_center = bc;
        q.b_extent = be;
        return q;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_word();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic int near(int base);
        return base + int'($urandom_range(400)) - 200;
    endfunction

    function automatic logic [LANE_W-1:0] rand_size();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 7)       return LANE_W'($urandom_range(320));
        else if (sel == 7) return LANE_W'($urandom);
        else if (sel == 8) return '0;
        return '1;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_extent();
        return {rand_size(), rand_size(), rand_size()};
    endfunction

    function automatic t_query_item random_query();
        t_query_item q;
        int unsigned sel;
        int          base [3];
        sel = $urandom_range(9);
        if ($urandom_range(99) < 8)
            q.command = ALL_CMDS[NUM_VALID_CMDS + $urandom_range(2)];
        else
            q.command = ALL_CMDS[$urandom_range(NUM_VALID_CMDS - 1)];
        if (sel < 2) begin
            q.a_center = rand_word();
            q.a_extent = rand_word();
            q.b_center = rand_word();
            q.b_extent = rand_word();
        end else begin
            // cluster both shapes around a common point so hits and misses mix
            for (int ax = 0; ax < 3; ax++)
                base[ax] = (sel < 7) ? 0 : int'($signed(LANE_W'($urandom)));
            q.a_center = xyz(near(base[0]), near(base[1]), near(base[2]));
            q.b_center = xyz(near(base[0]), near(base[1]), near(base[2]));
            q.a_extent = rand_extent();
            q.b_extent = rand_extent();
        end
        return q;
    endfunction

    function automatic int idle_pct(bit receiver);
        if (accepted_count < total_items / 3)          return receiver ? 86 : 27;
        else if (accepted_count < 2 * total_items / 3) return receiver ? 27 : 86;
        return 0;
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            query_ch.valid <= 1'b0;
        end else if (!query_ch.valid || query_ch.ready) begin
            if (query_ch.valid) begin
                expected_verdicts.push_back(predict_verdict(offered));
                accepted_count <= accepted_count + 1;
            end
            if (pending_queries.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
                offered = pending_queries.pop_front();
                query_ch.valid    <= 1'b1;
                query_ch.command  <= offered.command;
                query_ch.a_center <= offered.a_center;
                query_ch.a_extent <= offered.a_extent;
                query_ch.b_center <= offered.b_center;
                query_ch.b_extent <= offered.b_extent;
            end else begin
                query_ch.valid <= 1'b0;
            end
        end
    end

    // Long result stall once, while the sender keeps offering
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && accepted_count >= hold_at) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin : result_monitor
        t_verdict want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: result with no query pending: hit=%b bad_command=%b",
                             $time, result_ch.hit, result_ch.bad_command);
                    failures++;
                end else begin
                    want = expected_verdicts.pop_front();
                    checked_count++;
                    if (result_ch.hit !== want.hit) begin
                        $display("%0t: hit mismatch: expected %b, actual %b",
                                 $time, want.hit, result_ch.hit);
                        failures++;
                    end
                    if (result_ch.bad_command !== want.bad_command) begin
                        $display("%0t: bad_command mismatch: expected %b, actual %b",
                                 $time, want.bad_command, result_ch.bad_command);
                        failures++;
                    end
                    if (want.hit)         hits_seen++;
                    if (want.bad_command) rejects_seen++;
                end
            end
            result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        query_ch.valid    = 1'b0;
        query_ch.command  = '0;
        query_ch.a_center = '0;
        query_ch.a_extent = '0;
        query_ch.b_center = '0;
        query_ch.b_extent = '0;
        result_ch.ready   = 1'b0;

        // box against box: faces touching, one step apart, extremes, all zero
        pending_queries.push_back(mk_query(CMD_BOX_BOX, xyz(0, 0, 0), xyz(4, 4, 4),
                                           xyz(4, 0, 0), xyz(4, 4, 4)));
        pending_queries.push_back(mk_query(CMD_BOX_BOX, xyz(0, 0, 0), xyz(4, 4, 4),
                                           xyz(5, 0, 0), xyz(5, 4, 4)));
        pending_queries.push_back(mk_query(CMD_BOX_BOX, xyz(32767, 32767, 32767), ALL_ONES,
                                           xyz(-32768, -32768, -32768), ALL_ONES));
        pending_queries.push_back(mk_query(CMD_BOX_BOX, '0, '0, '0, '0));
        // point against box: on a face, just outside, flat box hit and miss
        pending_queries.push_back(mk_query(CMD_POINT_BOX, xyz(2, -2, 2), ALL_ONES,
                                           xyz(0, 0, 0), xyz(4, 4, 4)));
        pending_queries.push_back(mk_query(CMD_POINT_BOX, xyz(3, 0, 0), ALL_ONES,
                                           xyz(0, 0, 0), xyz(4, 4, 4)));
        pending_queries.push_back(mk_query(CMD_POINT_BOX, xyz(-100, 50, 7), '0,
                                           xyz(-100, 50, 7), '0));
        pending_queries.push_back(mk_query(CMD_POINT_BOX, xyz(-100, 50, 8), '0,
                                           xyz(-100, 50, 7), '0));
        // sphere against box: inside with junk in unused lanes, touching, overlapping, zero radius, extremes
        pending_queries.push_back(mk_query(CMD_SPHERE_BOX, xyz(1, 1, 1), {32'hFFFF_FFFF, 16'd2},
                                           xyz(0, 0, 0), xyz(4, 4, 4)));
        pending_queries.push_back(mk_query(CMD_SPHERE_BOX, xyz(4, 0, 0), xyz(2, 0, 0),
                                           xyz(0, 0, 0), xyz(4, 4, 4)));
        pending_queries.push_back(mk_query(CMD_SPHERE_BOX, xyz(4, 0, 0), xyz(3, 0, 0),
                                           xyz(0, 0, 0), xyz(4, 4, 4)));
        pending_queries.push_back(mk_query(CMD_SPHERE_BOX, xyz(0, 0, 0), '0,
                                           xyz(0, 0, 0), xyz(4, 4, 4)));
        pending_queries.push_back(mk_query(CMD_SPHERE_BOX, xyz(32767, 32767, 32767), ALL_ONES,
                                           xyz(-32768, -32768, -32768), '0));
        // sphere against sphere: touching, overlapping, zero radii, extremes
        pending_queries.push_back(mk_query(CMD_SPHERE_SPHERE, xyz(0, 0, 0), xyz(2, 0, 0),
                                           xyz(5, 0, 0), xyz(3, 0, 0)));
        pending_queries.push_back(mk_query(CMD_SPHERE_SPHERE, xyz(0, 0, 0), xyz(3, 0, 0),
                                           xyz(5, 0, 0), {32'hFFFF_FFFF, 16'd3}));
        pending_queries.push_back(mk_query(CMD_SPHERE_SPHERE, xyz(9, 9, 9), '0,
                                           xyz(9, 9, 9), '0));
        pending_queries.push_back(mk_query(CMD_SPHERE_SPHERE, xyz(-32768, -32768, -32768),
                                           ALL_ONES, xyz(32767, 32767, 32767), ALL_ONES));
        // point against sphere: on the surface, inside, zero radius, extremes
        pending_queries.push_back(mk_query(CMD_POINT_SPHERE, xyz(3, 4, 0), ALL_ONES,
                                           xyz(0, 0, 0), xyz(5, 0, 0)));
        pending_queries.push_back(mk_query(CMD_POINT_SPHERE, xyz(3, 4, 0), '0,
                                           xyz(0, 0, 0), xyz(6, 0, 0)));
        pending_queries.push_back(mk_query(CMD_POINT_SPHERE, xyz(-7, 7, -7), '0,
                                           xyz(-7, 7, -7), '0));
        pending_queries.push_back(mk_query(CMD_POINT_SPHERE, xyz(-32768, -32768, -32768),
                                           '0, xyz(32767, 32767, 32767), ALL_ONES));
        // reserved opcodes, with all-zero and all-ones geometry
        pending_queries.push_back(mk_query(CMD_RSVD_5, '0, '0, '0, '0));
        pending_queries.push_back(mk_query(CMD_RSVD_6, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
        pending_queries.push_back(mk_query(CMD_RSVD_7, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));

        repeat (RANDOM_QUERIES) pending_queries.push_back(random_query());
        total_items = pending_queries.size();
        hold_at     = 2 * total_items / 3 + 40;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_items || expected_verdicts.size() != 0)
            @(posedge i_clk);
        // drain: catch any stray result
        repeat (12) @(posedge i_clk);

        $display("Checked %0d queries over five tests and reserved opcodes,", checked_count);
        $display("three flow-control phases and one long stall: %0d hits, %0d rejected",
                 hits_seen, rejects_seen);
        if (failures == 0) begin
            $display("tb_box_sphere_intersection_unit OK");
        end else begin
            $display("tb_box_sphere_intersection_unit NOT OK");
        end
        $finish;
    end

endmodule
